>>> hw/rtl/bpc_pkg.sv
package bpc_pkg;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned CfgIdxWidth = 2;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_SHORT    = 2'd1,
    EV_LONG     = 2'd2,
    EV_LONG_HIT = 2'd3
  } press_ev_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_DEBOUNCE_TIME = 2'd0,
    REG_LONG_TIME     = 2'd1,
    REG_ACTIVE_LOW    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_time;
    logic [CfgWidth-1:0] long_time;
    logic                active_low;
  } cfg_t;

  localparam logic [CfgWidth-1:0] DebounceReset  = 16'd20;
  localparam logic [CfgWidth-1:0] LongTimeReset  = 16'd600;
  localparam logic                ActiveLowReset = 1'b1;

endpackage

>>> hw/rtl/bpc_core.sv
module bpc_core
  import bpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic                 raw_level,
  input  logic [TimeWidth-1:0] now_ms,
  input  cfg_t                 cfg,
  output press_ev_t            press_event
);

  logic                 stable_level_r, stable_level_nxt;
  logic                 last_raw_r;
  logic [TimeWidth-1:0] last_change_r, last_change_nxt;
  logic                 is_pressed_r, is_pressed_nxt;
  logic [TimeWidth-1:0] press_start_r, press_start_nxt;
  logic                 long_rep_r, long_rep_nxt;

  logic [TimeWidth-1:0] elapsed;
  logic [TimeWidth-1:0] held;
  logic                 settle;
  logic                 down;
  logic                 held_long;

  always_comb begin
    stable_level_nxt = stable_level_r;
    is_pressed_nxt   = is_pressed_r;
    press_start_nxt  = press_start_r;
    long_rep_nxt     = long_rep_r;
    press_event      = EV_NONE;

    last_change_nxt = (raw_level != last_raw_r) ? now_ms : last_change_r;
    elapsed = now_ms - last_change_nxt;
    settle  = (elapsed >= {{(TimeWidth-CfgWidth){1'b0}}, cfg.debounce_time}) &&
              (stable_level_r != raw_level);
    down    = raw_level ^ cfg.active_low;

    // A fresh press restarts the hold timer at this sample, so held is zero.
    if (settle && down && !is_pressed_r) begin
      held = '0;
    end else begin
      held = now_ms - press_start_r;
    end
    held_long = held >= {{(TimeWidth-CfgWidth){1'b0}}, cfg.long_time};

    if (settle) begin
      stable_level_nxt = raw_level;
    end

    if (settle && !down && is_pressed_r) begin
      is_pressed_nxt = 1'b0;
      long_rep_nxt   = 1'b0;
      press_event    = held_long ? EV_LONG : EV_SHORT;
    end else begin
      if (settle && down && !is_pressed_r) begin
        is_pressed_nxt  = 1'b1;
        press_start_nxt = now_ms;
        long_rep_nxt    = 1'b0;
      end
      if (is_pressed_nxt && !long_rep_nxt && held_long) begin
        long_rep_nxt = 1'b1;
        press_event  = EV_LONG_HIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_level_r <= 1'b1;
      last_raw_r     <= 1'b1;
      last_change_r  <= '0;
      is_pressed_r   <= 1'b0;
      press_start_r  <= '0;
      long_rep_r     <= 1'b0;
    end else if (fire) begin
      stable_level_r <= stable_level_nxt;
      last_raw_r     <= raw_level;
      last_change_r  <= last_change_nxt;
      is_pressed_r   <= is_pressed_nxt;
      press_start_r  <= press_start_nxt;
      long_rep_r     <= long_rep_nxt;
    end
  end

  a_long_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    long_rep_r |-> is_pressed_r)
    else $error("long event marked without a held press");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (press_event == EV_SHORT || press_event == EV_LONG) |=> !is_pressed_r)
    else $error("release reported but press still recorded");

  a_hit_marks: assert property (@(posedge clk) disable iff (!rst_n)
    fire && press_event == EV_LONG_HIT |=> long_rep_r && is_pressed_r)
    else $error("long threshold reported but not marked");

endmodule

>>> hw/rtl/button_press_classifier.sv
// An input beat is registered in stage s1, its result beat in the output register.
// Throughput: one sample per cycle while out_stall is low; the state update is a single
// pass of two 32-bit wrapping subtractions and compares between the input and result registers.
// Reset (rst_n low, synchronous): registers return to debounce 20 ms, long 600 ms,
// active low; button state reads released, and both pipeline stages are emptied.
module button_press_classifier
  import bpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_raw_level,
  input  logic [TimeWidth-1:0]   in_now_ms,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_press_event,
  input  logic                   cfg_wr_en,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_data
);

  cfg_t                 cfg_r;
  logic                 s1_vld_r;
  logic                 s1_raw_r;
  logic [TimeWidth-1:0] s1_now_r;
  logic                 out_vld_r;
  press_ev_t            out_ev_r;
  press_ev_t            core_ev;
  logic                 out_take;
  logic                 fire;

  assign out_take = !out_vld_r || !out_stall;
  assign fire     = s1_vld_r && out_take;
  assign in_stall = s1_vld_r && !out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time <= DebounceReset;
      cfg_r.long_time     <= LongTimeReset;
      cfg_r.active_low    <= ActiveLowReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEBOUNCE_TIME: cfg_r.debounce_time <= cfg_data;
        REG_LONG_TIME:     cfg_r.long_time     <= cfg_data;
        REG_ACTIVE_LOW:    cfg_r.active_low    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_raw_r <= in_raw_level;
      s1_now_r <= in_now_ms;
    end
  end

  bpc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .raw_level   (s1_raw_r),
    .now_ms      (s1_now_r),
    .cfg         (cfg_r),
    .press_event (core_ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_take) begin
      out_vld_r <= s1_vld_r;
    end
  end

  // The result beat only moves when the output side can take it.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_ev_r <= core_ev;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_press_event = out_ev_r;

endmodule
